// File: rtl/core/aes_pkg.sv
// Package for the AES block cipher: item types, register indexes,
// S-box tables and GF(2^8) helper functions.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package aes_pkg;

    // One input item: the 128-bit block in two halves.
    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_in_t;

    // One result item.
    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_out_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_255_192 = 3'd0;
    localparam logic [2:0] REG_KEY_191_128 = 3'd1;
    localparam logic [2:0] REG_KEY_127_64  = 3'd2;
    localparam logic [2:0] REG_KEY_63_0    = 3'd3;
    localparam logic [2:0] REG_MODE        = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        'h63,'h7c,'h77,'h7b,'hf2,'h6b,'h6f,'hc5,'h30,'h01,'h67,'h2b,'hfe,'hd7,'hab,'h76,
        'hca,'h82,'hc9,'h7d,'hfa,'h59,'h47,'hf0,'had,'hd4,'ha2,'haf,'h9c,'ha4,'h72,'hc0,
        'hb7,'hfd,'h93,'h26,'h36,'h3f,'hf7,'hcc,'h34,'ha5,'he5,'hf1,'h71,'hd8,'h31,'h15,
        'h04,'hc7,'h23,'hc3,'h18,'h96,'h05,'h9a,'h07,'h12,'h80,'he2,'heb,'h27,'hb2,'h75,
        'h09,'h83,'h2c,'h1a,'h1b,'h6e,'h5a,'ha0,'h52,'h3b,'hd6,'hb3,'h29,'he3,'h2f,'h84,
        'h53,'hd1,'h00,'hed,'h20,'hfc,'hb1,'h5b,'h6a,'hcb,'hbe,'h39,'h4a,'h4c,'h58,'hcf,
        'hd0,'hef,'haa,'hfb,'h43,'h4d,'h33,'h85,'h45,'hf9,'h02,'h7f,'h50,'h3c,'h9f,'ha8,
        'h51,'ha3,'h40,'h8f,'h92,'h9d,'h38,'hf5,'hbc,'hb6,'hda,'h21,'h10,'hff,'hf3,'hd2,
        'hcd,'h0c,'h13,'hec,'h5f,'h97,'h44,'h17,'hc4,'ha7,'h7e,'h3d,'h64,'h5d,'h19,'h73,
        'h60,'h81,'h4f,'hdc,'h22,'h2a,'h90,'h88,'h46,'hee,'hb8,'h14,'hde,'h5e,'h0b,'hdb,
        'he0,'h32,'h3a,'h0a,'h49,'h06,'h24,'h5c,'hc2,'hd3,'hac,'h62,'h91,'h95,'he4,'h79,
        'he7,'hc8,'h37,'h6d,'h8d,'hd5,'h4e,'ha9,'h6c,'h56,'hf4,'hea,'h65,'h7a,'hae,'h08,
        'hba,'h78,'h25,'h2e,'h1c,'ha6,'hb4,'hc6,'he8,'hdd,'h74,'h1f,'h4b,'hbd,'h8b,'h8a,
        'h70,'h3e,'hb5,'h66,'h48,'h03,'hf6,'h0e,'h61,'h35,'h57,'hb9,'h86,'hc1,'h1d,'h9e,
        'he1,'hf8,'h98,'h11,'h69,'hd9,'h8e,'h94,'h9b,'h1e,'h87,'he9,'hce,'h55,'h28,'hdf,
        'h8c,'ha1,'h89,'h0d,'hbf,'he6,'h42,'h68,'h41,'h99,'h2d,'h0f,'hb0,'h54,'hbb,'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        'h52,'h09,'h6a,'hd5,'h30,'h36,'ha5,'h38,'hbf,'h40,'ha3,'h9e,'h81,'hf3,'hd7,'hfb,
        'h7c,'he3,'h39,'h82,'h9b,'h2f,'hff,'h87,'h34,'h8e,'h43,'h44,'hc4,'hde,'he9,'hcb,
        'h54,'h7b,'h94,'h32,'ha6,'hc2,'h23,'h3d,'hee,'h4c,'h95,'h0b,'h42,'hfa,'hc3,'h4e,
        'h08,'h2e,'ha1,'h66,'h28,'hd9,'h24,'hb2,'h76,'h5b,'ha2,'h49,'h6d,'h8b,'hd1,'h25,
        'h72,'hf8,'hf6,'h64,'h86,'h68,'h98,'h16,'hd4,'ha4,'h5c,'hcc,'h5d,'h65,'hb6,'h92,
        'h6c,'h70,'h48,'h50,'hfd,'hed,'hb9,'hda,'h5e,'h15,'h46,'h57,'ha7,'h8d,'h9d,'h84,
        'h90,'hd8,'hab,'h00,'h8c,'hbc,'hd3,'h0a,'hf7,'he4,'h58,'h05,'hb8,'hb3,'h45,'h06,
        'hd0,'h2c,'h1e,'h8f,'hca,'h3f,'h0f,'h02,'hc1,'haf,'hbd,'h03,'h01,'h13,'h8a,'h6b,
        'h3a,'h91,'h11,'h41,'h4f,'h67,'hdc,'hea,'h97,'hf2,'hcf,'hce,'hf0,'hb4,'he6,'h73,
        'h96,'hac,'h74,'h22,'he7,'had,'h35,'h85,'he2,'hf9,'h37,'he8,'h1c,'h75,'hdf,'h6e,
        'h47,'hf1,'h1a,'h71,'h1d,'h29,'hc5,'h89,'h6f,'hb7,'h62,'h0e,'haa,'h18,'hbe,'h1b,
        'hfc,'h56,'h3e,'h4b,'hc6,'hd2,'h79,'h20,'h9a,'hdb,'hc0,'hfe,'h78,'hcd,'h5a,'hf4,
        'h1f,'hdd,'ha8,'h33,'h88,'h07,'hc7,'h31,'hb1,'h12,'h10,'h59,'h27,'h80,'hec,'h5f,
        'h60,'h51,'h7f,'ha9,'h19,'hb5,'h4a,'h0d,'h2d,'he5,'h7a,'h9f,'h93,'hc9,'h9c,'hef,
        'ha0,'he0,'h3b,'h4d,'hae,'h2a,'hf5,'hb0,'hc8,'heb,'hbb,'h3c,'h83,'h53,'h99,'h61,
        'h17,'h2b,'h04,'h7e,'hba,'h77,'hd6,'h26,'he1,'h69,'h14,'h63,'h55,'h21,'h0c,'h7d
    };

    // Multiply by x in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward MixColumns coefficient k of {2, 3, 1, 1}.
    function automatic logic [7:0] mul_fwd(input logic [7:0] a, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = xt(a);
            2'd1:    r = xt(a) ^ a;
            default: r = a;
        endcase
        return r;
    endfunction

    // Inverse MixColumns coefficient k of {E, B, D, 9}.
    function automatic logic [7:0] mul_inv(input logic [7:0] a, input logic [1:0] k);
        logic [7:0] a2;
        logic [7:0] a4;
        logic [7:0] a8;
        logic [7:0] r;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        case (k)
            2'd0:    r = a8 ^ a4 ^ a2;
            2'd1:    r = a8 ^ a2 ^ a;
            2'd2:    r = a8 ^ a4 ^ a;
            default: r = a8 ^ a;
        endcase
        return r;
    endfunction

    // S-box applied to each byte of a key word.
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/aes_key_sched.sv
// Round-key schedule: expands the cipher key one word per cycle into a
// row memory of 128-bit round keys and serves one registered read a cycle.
// Depends on aes_pkg.
`default_nettype none

module aes_key_sched
    import aes_pkg::*;
#(
    parameter int KEY_WORDS = 8,
    parameter int ROUNDS    = 14,
    parameter int ROWS      = ROUNDS + 1,
    parameter int AW        = $clog2(ROWS)
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start_i,
    input  wire logic [255:0]   key_i,
    input  wire logic [AW-1:0]  rd_addr_i,
    output logic      [127:0]   rk_o,
    output logic                busy_o
);

    localparam int WORDS = 4 * ROWS;
    localparam int WIW   = $clog2(WORDS);
    localparam int KMW   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    logic [127:0]   mem [ROWS];
    logic [127:0]   rk_reg;
    logic           busy_reg;
    logic [WIW-1:0] widx_reg;
    logic [KMW-1:0] kmod_reg;
    logic [7:0]     rc_reg;
    logic [31:0]    win_reg [KEY_WORDS];
    logic [95:0]    row_reg;
    logic [31:0]    keyw [8];
    logic [31:0]    tmp;
    logic [31:0]    new_word;
    logic           from_key;

    // Split the key register set into words, word 0 most significant.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            keyw[j] = key_i[255 - 32 * j -: 32];
        end
    end

    // Next schedule word from the sliding window of the last KEY_WORDS words.
    always_comb begin
        from_key = (widx_reg < WIW'(KEY_WORDS));
        tmp      = win_reg[KEY_WORDS-1];
        if (kmod_reg == '0) begin
            tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rc_reg, 24'h0};
        end else if (KEY_WORDS > 6 && kmod_reg == KMW'(4)) begin
            tmp = sub_word(tmp);
        end
        new_word = from_key ? keyw[widx_reg[2:0]] : (win_reg[0] ^ tmp);
    end

    // Expansion sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn || start_i) begin
            busy_reg <= 1'b1;
            widx_reg <= '0;
            kmod_reg <= '0;
            rc_reg   <= 8'h01;
        end else if (busy_reg) begin
            widx_reg <= widx_reg + 1'b1;
            kmod_reg <= (kmod_reg == KMW'(KEY_WORDS - 1)) ? '0 : kmod_reg + 1'b1;
            if (!from_key && kmod_reg == '0) begin
                rc_reg <= xt(rc_reg);
            end
            if (widx_reg == WIW'(WORDS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Word window and row assembly; a full row goes to memory.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            for (int j = 0; j < KEY_WORDS - 1; j++) begin
                win_reg[j] <= win_reg[j+1];
            end
            win_reg[KEY_WORDS-1] <= new_word;
            row_reg <= {row_reg[63:0], new_word};
            if (widx_reg[1:0] == 2'd3) begin
                mem[AW'(widx_reg >> 2)] <= {row_reg, new_word};
            end
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rk_reg <= mem[rd_addr_i];
    end

    assign rk_o   = rk_reg;
    assign busy_o = busy_reg;

endmodule

`default_nettype wire

// File: rtl/core/aes_round.sv
// One cipher round, forward or inverse, with an optional final-round form
// that skips MixColumns. Depends on aes_pkg.
`default_nettype none

module aes_round
    import aes_pkg::*;
(
    input  wire logic [127:0] state_i,
    input  wire logic [127:0] key_i,
    input  wire logic         dec_i,
    input  wire logic         last_i,
    output logic      [127:0] state_o
);

    logic [7:0] a  [16];
    logic [7:0] b  [16];
    logic [7:0] c  [16];
    logic [7:0] kb [16];
    logic [7:0] acc;

    always_comb begin
        for (int n = 0; n < 16; n++) begin
            a[n]  = state_i[127 - 8 * n -: 8];
            kb[n] = key_i[127 - 8 * n -: 8];
        end
        // Byte substitution and row shift, byte 4*col+row.
        for (int cl = 0; cl < 4; cl++) begin
            for (int r = 0; r < 4; r++) begin
                if (dec_i) begin
                    b[4*cl+r] = INV_SBOX[a[4*((cl-r+4)%4)+r]] ^ kb[4*cl+r];
                end else begin
                    b[4*cl+r] = SBOX[a[4*((cl+r)%4)+r]];
                end
            end
        end
        // Column mixing; the inverse cipher adds the key before it.
        for (int cl = 0; cl < 4; cl++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) begin
                    if (dec_i) begin
                        acc = acc ^ mul_inv(b[4*cl+j], 2'((j - r + 4) % 4));
                    end else begin
                        acc = acc ^ mul_fwd(b[4*cl+j], 2'((j - r + 4) % 4));
                    end
                end
                if (last_i) begin
                    acc = b[4*cl+r];
                end
                c[4*cl+r] = dec_i ? acc : (acc ^ kb[4*cl+r]);
            end
        end
        for (int n = 0; n < 16; n++) begin
            state_o[127 - 8 * n -: 8] = c[n];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/aes256_block_cipher.sv
// AES block cipher top level: one round per cycle through a shared round unit.
// Each item gets the key add at accept, then ROUNDS (default 14) rounds.
// The single round unit takes a new item only once the last result is registered.
// Reset expands the all-zero key schedule, with the input not ready meanwhile;
// each key write repeats that expansion. Any write drops s_ready in the cycle after it.
// Depends on aes_pkg, aes_key_sched and aes_round.
`default_nettype none

module aes256_block_cipher
    import aes_pkg::*;
#(
    parameter int KEY_WORDS = 8,
    parameter int ROUNDS    = 14
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire aes_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output aes_out_t      m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int AW = $clog2(ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t       state_reg;
    logic [63:0]  key_reg [4];
    logic         dec_reg;
    logic         prime_reg;
    logic [AW-1:0] rnd_reg;
    logic [127:0] blk_reg;
    logic [127:0] blk_next;
    aes_out_t     out_reg;
    logic         mv_reg;
    logic         cfg_we;
    logic         key_we;
    logic         s_acc;
    logic         slot_free;
    logic         out_load;
    logic         ks_busy;
    logic [127:0] rk;
    logic [127:0] round_out;
    logic [AW-1:0] k_sel;
    logic [AW-1:0] rd_addr;
    logic         last_rnd;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign key_we    = cfg_we && (cfg_index == REG_KEY_255_192 || cfg_index == REG_KEY_191_128
                                 || cfg_index == REG_KEY_127_64 || cfg_index == REG_KEY_63_0);
    assign s_ready   = (state_reg == ST_IDLE) && prime_reg && !ks_busy;
    assign s_acc     = s_valid && s_ready;
    assign slot_free = !mv_reg || m_ready;
    assign last_rnd  = (rnd_reg == AW'(ROUNDS));
    assign out_load  = slot_free && ((state_reg == ST_RUN && last_rnd) || state_reg == ST_HOLD);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 4; j++) begin
                key_reg[j] <= '0;
            end
            dec_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY_255_192: key_reg[0] <= cfg_data;
                REG_KEY_191_128: key_reg[1] <= cfg_data;
                REG_KEY_127_64:  key_reg[2] <= cfg_data;
                REG_KEY_63_0:    key_reg[3] <= cfg_data;
                REG_MODE:        dec_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // The round-key read port must settle on the first key before an item enters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg <= 1'b0;
        end else begin
            prime_reg <= !cfg_we && !ks_busy;
        end
    end

    // Round-key row that the next cycle needs; decryption walks the rows backward.
    always_comb begin
        if (state_reg == ST_RUN) begin
            k_sel = last_rnd ? '0 : rnd_reg + 1'b1;
        end else begin
            k_sel = s_acc ? AW'(1) : '0;
        end
        rd_addr = dec_reg ? AW'(ROUNDS) - k_sel : k_sel;
    end

    aes_key_sched #(
        .KEY_WORDS (KEY_WORDS),
        .ROUNDS    (ROUNDS)
    ) u_ks (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (key_we),
        .key_i     ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .rd_addr_i (rd_addr),
        .rk_o      (rk),
        .busy_o    (ks_busy)
    );

    aes_round u_round (
        .state_i (blk_reg),
        .key_i   (rk),
        .dec_i   (dec_reg),
        .last_i  (last_rnd),
        .state_o (round_out)
    );

    // Block register: initial key add on accept, then one round a cycle.
    always_comb begin
        blk_next = blk_reg;
        if (s_acc) begin
            blk_next = {s_data.block_high, s_data.block_low} ^ rk;
        end else if (state_reg == ST_RUN) begin
            blk_next = round_out;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

    // Round sequencer and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        state_reg <= ST_RUN;
                        rnd_reg   <= AW'(1);
                    end
                end
                ST_RUN: begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (last_rnd) begin
                        state_reg <= slot_free ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result register: the final round output, or the held block after a stall.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= (state_reg == ST_HOLD) ? blk_reg : round_out;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// File: rtl/core/aes_checker.sv
// Port-level checks for the AES block cipher, bound to the top level.
// Depends on aes_pkg and aes256_block_cipher.
`default_nettype none

module aes_checker
    import aes_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire aes_out_t m_data,
    input wire logic     cfg_valid,
    input wire logic     cfg_ready
);

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The shared round unit takes one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted during rounds");

    // A configuration write drops s_ready, holding off the next item.
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("item accepted before round keys settled");

    // No result can appear the cycle after an item enters.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result came too early");

endmodule

bind aes256_block_cipher aes_checker u_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
